### hdl/fpsm_pkg.sv
package fpsm_pkg;

   // Grid geometry.
   localparam int MAX_ROW_LENGTH = 1024;
   localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_W          = COL_W + 1;
   localparam int WINDOW_DEPTH   = 2 * MAX_ROW_LENGTH;
   localparam int ADDR_W         = $clog2(WINDOW_DEPTH);
   localparam int ROW_W          = 17;

   // Field and register widths.
   localparam int SAMPLE_W      = 32;
   localparam int COEFF_W       = 48;
   localparam int RESULT_W      = 64;
   localparam int ROW_LEN_REG_W = 11;
   localparam int ROW_CNT_W     = 16;
   localparam int CSR_DATA_W    = 48;
   localparam int CSR_INDEX_W   = 3;

   // Arithmetic widths: neighbor sums, split coefficient products and the total.
   localparam int SUM_W       = SAMPLE_W + 1;
   localparam int COEFF_LO_W  = COEFF_W / 2;
   localparam int COEFF_HI_W  = COEFF_W - COEFF_LO_W;
   localparam int LO_PROD_W   = COEFF_LO_W + 1 + SUM_W;
   localparam int HI_PROD_W   = COEFF_HI_W + SUM_W;
   localparam int TERM_W      = COEFF_W + SUM_W;
   localparam int TOTAL_W     = TERM_W + 3;
   localparam int ROUND_SHIFT = 16;
   localparam int SHIFTED_W   = TOTAL_W - ROUND_SHIFT;

   localparam logic signed [TOTAL_W-1:0] ROUND_HALF = TOTAL_W'(1) << (ROUND_SHIFT - 1);
   localparam logic signed [RESULT_W-1:0] RESULT_MAX = {1'b0, {(RESULT_W - 1){1'b1}}};
   localparam logic signed [RESULT_W-1:0] RESULT_MIN = {1'b1, {(RESULT_W - 1){1'b0}}};

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_COEFF     = 3'd0,
      CSR_HORIZONTAL_COEFF = 3'd1,
      CSR_VERTICAL_COEFF   = 3'd2,
      CSR_ROW_LENGTH       = 3'd3,
      CSR_ROW_COUNT        = 3'd4
   } csr_index_type;

   // Five neighbors of one interior point, handed from the window to the datapath.
   typedef struct packed {
      logic                       valid;
      logic                       last;
      logic signed [SAMPLE_W-1:0] west;
      logic signed [SAMPLE_W-1:0] centre;
      logic signed [SAMPLE_W-1:0] east;
      logic signed [SAMPLE_W-1:0] south;
      logic signed [SAMPLE_W-1:0] north;
   } stencil_taps_type;

endpackage

### hdl/fpsm_window.sv
module fpsm_window (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [fpsm_pkg::LEN_W-1:0]            row_len,
   input  logic [fpsm_pkg::ROW_CNT_W-1:0]        row_cnt,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [fpsm_pkg::SAMPLE_W-1:0]  in_sample,
   output fpsm_pkg::stencil_taps_type            taps,
   input  logic                                  taps_ready
);

   // Two-row line buffer: bank row[0] holds the row two back, the other bank the row above.
   logic [fpsm_pkg::SAMPLE_W-1:0] window_mem [fpsm_pkg::WINDOW_DEPTH];

   logic [fpsm_pkg::COL_W-1:0]  col_ff, col_in;
   logic [fpsm_pkg::ROW_W-1:0]  row_ff, row_in;
   logic                        occ_ff, occ_in;

   logic [fpsm_pkg::SAMPLE_W-1:0]        south_rd_ff, east_rd_ff;
   logic signed [fpsm_pkg::SAMPLE_W-1:0] north_ff;
   logic emit_ff, last_ff, has_west_ff, has_east_ff, last_col_ff, fwd_ff;

   logic signed [fpsm_pkg::SAMPLE_W-1:0] west_ff, centre_ff;

   logic                         accept;
   logic                         leave;
   logic [fpsm_pkg::LEN_W-1:0]   col_plus1;
   logic                         last_col;
   logic                         last_row;
   logic                         bank;
   logic [fpsm_pkg::ADDR_W-1:0]  wr_addr, east_addr;
   logic signed [fpsm_pkg::SAMPLE_W-1:0] east_val;

   function automatic logic [fpsm_pkg::ADDR_W-1:0] window_addr(
      input logic sel, input logic [fpsm_pkg::COL_W-1:0] col);
      logic [fpsm_pkg::ADDR_W-1:0] base;
      base = sel ? fpsm_pkg::ADDR_W'(fpsm_pkg::MAX_ROW_LENGTH) : '0;
      return base + fpsm_pkg::ADDR_W'(col);
   endfunction

   assign in_ready = !occ_ff || taps_ready;
   assign accept   = in_valid && in_ready;
   assign leave    = occ_ff && taps_ready;

   // Position decode for the incoming sample.
   assign col_plus1 = fpsm_pkg::LEN_W'(col_ff) + fpsm_pkg::LEN_W'(1);
   assign last_col  = col_plus1 >= row_len;
   assign last_row  = row_ff >= (fpsm_pkg::ROW_W'(row_cnt) + fpsm_pkg::ROW_W'(1));
   assign bank      = row_ff[0];

   // South and the write share one entry; the east port prefetches the next
   // row's first centre at the end of each row.
   assign wr_addr   = window_addr(bank, col_ff);
   assign east_addr = last_col ? window_addr(bank, '0)
                               : window_addr(!bank, col_plus1[fpsm_pkg::COL_W-1:0]);

   // Read-first memory: the south read sees the entry before this sample overwrites it.
   always_ff @(posedge clock) begin
      if (accept) begin
         south_rd_ff       <= window_mem[wr_addr];
         east_rd_ff        <= window_mem[east_addr];
         window_mem[wr_addr] <= in_sample;
      end
   end

   // Column and row counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + fpsm_pkg::ROW_W'(1);
         end else begin
            col_in = col_plus1[fpsm_pkg::COL_W-1:0];
         end
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (accept) begin
         occ_in = 1'b1;
      end else if (taps_ready) begin
         occ_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         occ_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         occ_ff <= occ_in;
      end
   end

   // Per-transaction flags that travel with the memory read data.
   always_ff @(posedge clock) begin
      if (accept) begin
         north_ff    <= in_sample;
         emit_ff     <= row_ff >= fpsm_pkg::ROW_W'(2);
         last_ff     <= last_row && last_col;
         has_west_ff <= col_ff != '0;
         has_east_ff <= !last_col;
         last_col_ff <= last_col;
         fwd_ff      <= last_col && (col_ff == '0);
      end
   end

   // With a one-point row the prefetched entry is the one just written.
   assign east_val = fwd_ff ? north_ff : $signed(east_rd_ff);

   // West and centre of the row above slide along as the east read arrives.
   always_ff @(posedge clock) begin
      if (leave) begin
         if (last_col_ff) begin
            centre_ff <= east_val;
         end else begin
            west_ff   <= centre_ff;
            centre_ff <= east_val;
         end
      end
   end

   always_comb begin
      taps.valid  = occ_ff && emit_ff;
      taps.last   = last_ff;
      taps.west   = has_west_ff ? west_ff : '0;
      taps.centre = centre_ff;
      taps.east   = has_east_ff ? east_val : '0;
      taps.south  = $signed(south_rd_ff);
      taps.north  = north_ff;
   end

endmodule

### hdl/fpsm_datapath.sv
module fpsm_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [fpsm_pkg::COEFF_W-1:0]    center_coeff,
   input  logic signed [fpsm_pkg::COEFF_W-1:0]    horizontal_coeff,
   input  logic signed [fpsm_pkg::COEFF_W-1:0]    vertical_coeff,
   input  fpsm_pkg::stencil_taps_type             taps,
   output logic                                   taps_ready,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [fpsm_pkg::RESULT_W-1:0]   out_value,
   output logic                                   out_last
);

   localparam int STAGES = 5;
   localparam int LO = fpsm_pkg::COEFF_LO_W;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] stage_ready;
   logic [STAGES-1:0] last_ff;

   // Stage 0: neighbor sums.
   logic signed [fpsm_pkg::SUM_W-1:0] hsum_ff, vsum_ff, ctr_ff;
   // Stage 1: split products, low coefficient half unsigned.
   logic signed [fpsm_pkg::LO_PROD_W-1:0] c_lo_ff, h_lo_ff, v_lo_ff;
   logic signed [fpsm_pkg::HI_PROD_W-1:0] c_hi_ff, h_hi_ff, v_hi_ff;
   // Stage 2: full terms.
   logic signed [fpsm_pkg::TERM_W-1:0] c_term_ff, h_term_ff, v_term_ff;
   // Stage 3: rounded total.
   logic signed [fpsm_pkg::TOTAL_W-1:0] total_ff;
   // Stage 4: saturated result.
   logic signed [fpsm_pkg::RESULT_W-1:0] result_ff;

   logic signed [fpsm_pkg::SHIFTED_W-1:0]         shifted;
   logic [fpsm_pkg::SHIFTED_W-fpsm_pkg::RESULT_W:0] hi_part;
   logic                                          overflow;

   // Elastic pipeline: a stage takes new data when it is empty or emptying.
   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      valid_in[0] = stage_ready[0] ? taps.valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign taps_ready = stage_ready[0];

   // The end-of-block flag travels beside the data, one bit per stage.
   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         last_ff[0] <= taps.last;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (stage_ready[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   // Neighbor sums.
   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         hsum_ff    <= fpsm_pkg::SUM_W'(taps.west) + fpsm_pkg::SUM_W'(taps.east);
         vsum_ff    <= fpsm_pkg::SUM_W'(taps.south) + fpsm_pkg::SUM_W'(taps.north);
         ctr_ff     <= fpsm_pkg::SUM_W'(taps.centre);
      end
   end

   // Coefficient halves times the sums.
   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         c_lo_ff    <= $signed({1'b0, center_coeff[LO-1:0]}) * ctr_ff;
         h_lo_ff    <= $signed({1'b0, horizontal_coeff[LO-1:0]}) * hsum_ff;
         v_lo_ff    <= $signed({1'b0, vertical_coeff[LO-1:0]}) * vsum_ff;
         c_hi_ff    <= $signed(center_coeff[fpsm_pkg::COEFF_W-1:LO]) * ctr_ff;
         h_hi_ff    <= $signed(horizontal_coeff[fpsm_pkg::COEFF_W-1:LO]) * hsum_ff;
         v_hi_ff    <= $signed(vertical_coeff[fpsm_pkg::COEFF_W-1:LO]) * vsum_ff;
      end
   end

   // Recombine the halves of each product.
   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         c_term_ff  <= (fpsm_pkg::TERM_W'(c_hi_ff) <<< LO) + fpsm_pkg::TERM_W'(c_lo_ff);
         h_term_ff  <= (fpsm_pkg::TERM_W'(h_hi_ff) <<< LO) + fpsm_pkg::TERM_W'(h_lo_ff);
         v_term_ff  <= (fpsm_pkg::TERM_W'(v_hi_ff) <<< LO) + fpsm_pkg::TERM_W'(v_lo_ff);
      end
   end

   // Sum of the three terms plus half an output LSB for round half up.
   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         total_ff   <= fpsm_pkg::TOTAL_W'(c_term_ff) + fpsm_pkg::TOTAL_W'(h_term_ff)
                     + fpsm_pkg::TOTAL_W'(v_term_ff) + fpsm_pkg::ROUND_HALF;
      end
   end

   // Drop the fraction bits and clamp to the 64-bit range.
   assign shifted  = fpsm_pkg::SHIFTED_W'(total_ff >>> fpsm_pkg::ROUND_SHIFT);
   assign hi_part  = shifted[fpsm_pkg::SHIFTED_W-1:fpsm_pkg::RESULT_W-1];
   assign overflow = (|hi_part) && !(&hi_part);

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         if (overflow) begin
            result_ff <= shifted[fpsm_pkg::SHIFTED_W-1] ? fpsm_pkg::RESULT_MIN
                                                        : fpsm_pkg::RESULT_MAX;
         end else begin
            result_ff <= shifted[fpsm_pkg::RESULT_W-1:0];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_value = result_ff;
   assign out_last  = last_ff[STAGES-1];

endmodule

### hdl/five_point_stencil_matvec.sv
// Five-point stencil over a grid streamed in row-major order.
// Request channel (req_valid/req_ready/req_sample_value): one Q16.16 value per
// transaction; a lower ghost row, row_count interior rows and an upper ghost
// row, each row_length values long. The first two rows of a block produce no
// result; every later value produces the result for the point one row above.
// Response channel (rsp_valid/rsp_ready): saturated Q48.16 stencil value, with
// rsp_last_result marking the final interior point of the block.
// Throughput is one value per cycle while the response is not stalled: each
// transaction makes one read on each port of the two-row line buffer memory
// and one write. A result passes the memory read, sums, split products, term
// recombine, total and saturate registers on its way to rsp_valid.
// If the receiver stalls, the output register holds and the pipeline keeps
// accepting until every stage is full; only then does req_ready drop.
// Reset clears the row and column position, the pipeline and the registers
// (coefficients 0, row_length 1, row_count 1), not the line buffer; no result
// uses an unwritten entry. Unchecked by the block, the registers are written
// through csr_write_enable/csr_index/csr_write_data by the user only while idle.
module five_point_stencil_matvec (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [fpsm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [fpsm_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [fpsm_pkg::SAMPLE_W-1:0]   req_sample_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [fpsm_pkg::RESULT_W-1:0]   rsp_stencil_value,
   output logic                                   rsp_last_result
);

   logic signed [fpsm_pkg::COEFF_W-1:0]   center_coeff_ff;
   logic signed [fpsm_pkg::COEFF_W-1:0]   horizontal_coeff_ff;
   logic signed [fpsm_pkg::COEFF_W-1:0]   vertical_coeff_ff;
   logic [fpsm_pkg::ROW_LEN_REG_W-1:0]    row_length_ff;
   logic [fpsm_pkg::ROW_CNT_W-1:0]        row_count_ff;

   logic [fpsm_pkg::LEN_W-1:0]            len_eff;
   logic [fpsm_pkg::ROW_CNT_W-1:0]        cnt_eff;
   fpsm_pkg::stencil_taps_type            taps;
   logic                                  taps_ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         center_coeff_ff     <= '0;
         horizontal_coeff_ff <= '0;
         vertical_coeff_ff   <= '0;
         row_length_ff       <= fpsm_pkg::ROW_LEN_REG_W'(1);
         row_count_ff        <= fpsm_pkg::ROW_CNT_W'(1);
      end else if (csr_write_enable) begin
         case (fpsm_pkg::csr_index_type'(csr_index))
            fpsm_pkg::CSR_CENTER_COEFF: begin
               center_coeff_ff <= csr_write_data[fpsm_pkg::COEFF_W-1:0];
            end
            fpsm_pkg::CSR_HORIZONTAL_COEFF: begin
               horizontal_coeff_ff <= csr_write_data[fpsm_pkg::COEFF_W-1:0];
            end
            fpsm_pkg::CSR_VERTICAL_COEFF: begin
               vertical_coeff_ff <= csr_write_data[fpsm_pkg::COEFF_W-1:0];
            end
            fpsm_pkg::CSR_ROW_LENGTH: begin
               row_length_ff <= csr_write_data[fpsm_pkg::ROW_LEN_REG_W-1:0];
            end
            fpsm_pkg::CSR_ROW_COUNT: begin
               row_count_ff <= csr_write_data[fpsm_pkg::ROW_CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Zero row length or count means one; long rows are limited to the buffer size.
   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = fpsm_pkg::LEN_W'(1);
      end else if (32'(row_length_ff) > 32'(fpsm_pkg::MAX_ROW_LENGTH)) begin
         len_eff = fpsm_pkg::LEN_W'(fpsm_pkg::MAX_ROW_LENGTH);
      end else begin
         len_eff = fpsm_pkg::LEN_W'(row_length_ff);
      end
      cnt_eff = (row_count_ff == '0) ? fpsm_pkg::ROW_CNT_W'(1) : row_count_ff;
   end

   fpsm_window u_window (
      .clock      (clock),
      .reset      (reset),
      .row_len    (len_eff),
      .row_cnt    (cnt_eff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_sample  (req_sample_value),
      .taps       (taps),
      .taps_ready (taps_ready)
   );

   fpsm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .center_coeff     (center_coeff_ff),
      .horizontal_coeff (horizontal_coeff_ff),
      .vertical_coeff   (vertical_coeff_ff),
      .taps             (taps),
      .taps_ready       (taps_ready),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_value        (rsp_stencil_value),
      .out_last         (rsp_last_result)
   );

   // Input backpressure only ever comes from a stalled result at the output.
   a_backpressure_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a stalled response");

   // Reset empties the whole pipeline.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("pipeline not empty after reset");

endmodule
